### hdl/wgust_pkg.sv
// ----------------------------------------------------------------------------
// wgust_pkg
// Shared widths, limits and types for the wind and gust unit.
// ----------------------------------------------------------------------------
package wgust_pkg;

  localparam int READ_W   = 16;  // pulse counter reading
  localparam int FACTOR_W = 4;   // speed factor register
  localparam int WIND_W   = 12;  // wind speed result
  localparam int GUST_W   = 16;  // gust speed result
  localparam int IDX_W    = 6;   // tick index within a window
  localparam int HEAD_W   = 2;   // gust ring head
  // factor * count plus half a divisor stays below 2^20
  localparam int NUM_W    = 20;

  typedef logic [READ_W-1:0]   reading_t;
  typedef logic [FACTOR_W-1:0] factor_t;
  typedef logic [WIND_W-1:0]   wind_t;
  typedef logic [GUST_W-1:0]   gust_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [HEAD_W-1:0]   head_t;
  typedef logic [NUM_W-1:0]    num_t;

  localparam factor_t FACTOR_RESET = factor_t'(4);
  localparam num_t    WIND_MAX     = num_t'(4095);
  localparam num_t    GUST_MAX     = num_t'(65535);

  // stage advance strobes for the two-stage constant divider
  typedef struct packed {
    logic adv_a;
    logic adv_b;
  } cdiv_en_t;

endpackage

### hdl/wgust_in_if.sv
// ----------------------------------------------------------------------------
// wgust_in_if
// Sample tick channel: one counter reading per word.
// ----------------------------------------------------------------------------
interface wgust_in_if;

  logic                valid;
  logic                ready;
  wgust_pkg::reading_t counter_reading;

  modport source (output valid, output counter_reading, input ready);
  modport sink   (input valid, input counter_reading, output ready);

endinterface

### hdl/wgust_out_if.sv
// ----------------------------------------------------------------------------
// wgust_out_if
// Result channel: held speeds, window flag and tick delta per word.
// ----------------------------------------------------------------------------
interface wgust_out_if;

  logic                valid;
  logic                ready;
  wgust_pkg::wind_t    wind_speed;
  wgust_pkg::gust_t    gust_speed;
  logic                window_done;
  wgust_pkg::reading_t tick_delta;

  modport source (output valid, output wind_speed, output gust_speed,
                  output window_done, output tick_delta, input ready);
  modport sink   (input valid, input wind_speed, input gust_speed,
                  input window_done, input tick_delta, output ready);

endinterface

### hdl/wgust_cdiv.sv
// ----------------------------------------------------------------------------
// wgust_cdiv
// Two-stage divide by a constant: reciprocal multiply, then one
// remainder correction step.
// ----------------------------------------------------------------------------
module wgust_cdiv #(
  parameter int unsigned DEN = 4
) (
  input  logic                clk,
  input  wgust_pkg::cdiv_en_t en,
  input  wgust_pkg::num_t     num_i,
  output wgust_pkg::num_t     quot_o
);
  import wgust_pkg::*;

  localparam int PROD_W = 2 * NUM_W + 1;
  // floor(2^NUM_W / DEN); estimate is exact or one low
  localparam logic [NUM_W:0] RECIP = (NUM_W+1)'((64'd1 << NUM_W) / DEN);

  logic [PROD_W-1:0] prod;
  num_t              q0_r;
  num_t              num_a_r;
  num_t              rem;
  num_t              quot_r;

  // stage A: quotient estimate
  assign prod = PROD_W'(num_i) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en.adv_a) begin
      q0_r    <= prod[NUM_W +: NUM_W];
      num_a_r <= num_i;
    end
  end

  // stage B: remainder check and correction
  assign rem = num_a_r - num_t'(q0_r * DEN);

  always_ff @(posedge clk) begin
    if (en.adv_b) begin
      quot_r <= (rem >= num_t'(DEN)) ? q0_r + num_t'(1) : q0_r;
    end
  end

  assign quot_o = quot_r;

endmodule

### hdl/wind_gust_from_pulse_counts_unit.sv
// ----------------------------------------------------------------------------
// wind_gust_from_pulse_counts_unit
// Windowed wind speed and ring-maximum gust from a wrapping pulse counter.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   in_ch    | in  | valid / ready       | counter_reading
//   out_ch   | out | valid / ready       | wind_speed, gust_speed,
//            |     |                     | window_done, tick_delta
//   cfg_     | in  | cfg_we (no ready)   | cfg_wdata = speed_factor
//
// One word per cycle sustained while out_ch is ready; a result word passes,
// once its input is accepted, through five registers: input register, window
// tracking, two divider stages, result register.
// Every stage has its own valid bit and loads when empty or when the stage
// after it moves, so bubbles close up; a held result blocks input only once
// every stage is full.
// Reset (synchronous, rst_n low) empties the pipe, clears the window state
// and the gust ring, and loads speed_factor with 4.
// ----------------------------------------------------------------------------
module wind_gust_from_pulse_counts_unit #(
  parameter int SAMPLES_PER_WINDOW = 60,
  parameter int SAMPLE_SECONDS     = 4,
  parameter int GUST_DEPTH         = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  wgust_in_if.sink             in_ch,
  wgust_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  wgust_pkg::factor_t   cfg_wdata
);
  import wgust_pkg::*;

  localparam int TOTAL_SECS = SAMPLE_SECONDS * SAMPLES_PER_WINDOW;

  // config
  factor_t factor_r;

  // pipeline valids and loads
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic load1, load2, load3, load4, load_o;

  // stage 1 payload
  reading_t read1_r;

  // window state
  logic     origin_valid_r;
  reading_t origin_r;
  reading_t win_count_r;
  reading_t largest_r;
  idx_t     tick_idx_r;

  // stage 2 logic and payload
  reading_t count, delta, largest_n, delta2_nxt;
  idx_t     idx_n;
  logic     done2_nxt;
  num_t     num_w, num_g;
  reading_t delta2_r, delta3_r, delta4_r;
  logic     done2_r, done3_r, done4_r;
  num_t     num_w2_r, num_g2_r;

  // divider outputs
  cdiv_en_t div_en;
  num_t     wind_q, gust_q;

  // result stage
  wind_t    held_wind_r;
  gust_t    held_gust_r;
  logic     out_done_r;
  reading_t out_delta_r;
  gust_t    ring_r   [GUST_DEPTH];
  gust_t    ring_nxt [GUST_DEPTH];
  head_t    head_r, head_nxt;
  wind_t    wind_sat;
  gust_t    gust_sat, ring_max;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RESET;
    end else if (cfg_we) begin
      factor_r <= cfg_wdata;
    end
  end

  // backpressure chain: a stage loads when empty or when draining
  assign load_o = !out_valid_r || out_ch.ready;
  assign load4  = !v4_r || load_o;
  assign load3  = !v3_r || load4;
  assign load2  = !v2_r || load3;
  assign load1  = !v1_r || load2;
  assign in_ch.ready = load1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load1)  v1_r        <= in_ch.valid;
      if (load2)  v2_r        <= v1_r;
      if (load3)  v3_r        <= v2_r;
      if (load4)  v4_r        <= v3_r;
      if (load_o) out_valid_r <= v4_r;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (load1) read1_r <= in_ch.counter_reading;
  end

  // stage 2: counts since origin and previous tick, window end test
  always_comb begin
    count     = read1_r - origin_r;
    delta     = count - win_count_r;
    largest_n = (delta > largest_r) ? delta : largest_r;
    idx_n     = tick_idx_r + idx_t'(1);
    done2_nxt = origin_valid_r && (idx_n >= idx_t'(SAMPLES_PER_WINDOW));
    delta2_nxt = origin_valid_r ? delta : '0;
    num_w     = num_t'(factor_r) * num_t'(count) + num_t'(TOTAL_SECS / 2);
    num_g     = num_t'(factor_r) * num_t'(largest_n) + num_t'(SAMPLE_SECONDS / 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_valid_r <= 1'b0;
      origin_r       <= '0;
      win_count_r    <= '0;
      largest_r      <= '0;
      tick_idx_r     <= '0;
    end else if (load2 && v1_r) begin
      origin_valid_r <= 1'b1;
      if (!origin_valid_r || done2_nxt) begin
        origin_r    <= read1_r;
        win_count_r <= '0;
        largest_r   <= '0;
        tick_idx_r  <= '0;
      end else begin
        win_count_r <= count;
        largest_r   <= largest_n;
        tick_idx_r  <= idx_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      delta2_r <= delta2_nxt;
      done2_r  <= done2_nxt;
      num_w2_r <= num_w;
      num_g2_r <= num_g;
    end
  end

  // stages 3 and 4: rounded divides, sideband rides alongside
  assign div_en.adv_a = load3;
  assign div_en.adv_b = load4;

  wgust_cdiv #(.DEN(TOTAL_SECS)) u_div_wind (
    .clk    (clk),
    .en     (div_en),
    .num_i  (num_w2_r),
    .quot_o (wind_q)
  );

  wgust_cdiv #(.DEN(SAMPLE_SECONDS)) u_div_gust (
    .clk    (clk),
    .en     (div_en),
    .num_i  (num_g2_r),
    .quot_o (gust_q)
  );

  always_ff @(posedge clk) begin
    if (load3) begin
      delta3_r <= delta2_r;
      done3_r  <= done2_r;
    end
    if (load4) begin
      delta4_r <= delta3_r;
      done4_r  <= done3_r;
    end
  end

  // result stage: saturate, push gust into ring, take ring max
  always_comb begin
    wind_sat = (wind_q > WIND_MAX) ? wind_t'(WIND_MAX) : wind_q[WIND_W-1:0];
    gust_sat = (gust_q > GUST_MAX) ? gust_t'(GUST_MAX) : gust_q[GUST_W-1:0];
    head_nxt = (head_r == head_t'(GUST_DEPTH - 1)) ? '0 : head_r + head_t'(1);
    ring_max = '0;
    for (int i = 0; i < GUST_DEPTH; i++) begin
      ring_nxt[i] = (head_r == head_t'(i)) ? gust_sat : ring_r[i];
      if (ring_nxt[i] > ring_max) ring_max = ring_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_wind_r <= '0;
      held_gust_r <= '0;
      head_r      <= '0;
      for (int i = 0; i < GUST_DEPTH; i++) ring_r[i] <= '0;
    end else if (load_o && v4_r && done4_r) begin
      held_wind_r <= wind_sat;
      held_gust_r <= ring_max;
      head_r      <= head_nxt;
      for (int i = 0; i < GUST_DEPTH; i++) ring_r[i] <= ring_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      out_done_r  <= done4_r;
      out_delta_r <= delta4_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.wind_speed  = held_wind_r;
  assign out_ch.gust_speed  = held_gust_r;
  assign out_ch.window_done = out_done_r;
  assign out_ch.tick_delta  = out_delta_r;

`ifndef SYNTHESIS
  // tick index never reaches the window length
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_idx_r < idx_t'(SAMPLES_PER_WINDOW))
    else $error("tick index out of window range");

  // before the origin tick the window state is clear
  a_origin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !origin_valid_r |-> (win_count_r == '0 && largest_r == '0 && tick_idx_r == '0))
    else $error("window state set without origin");

  // ring head stays inside the ring
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < head_t'(GUST_DEPTH))
    else $error("gust ring head out of range");

  // held gust covers every ring entry
  for (genvar g = 0; g < GUST_DEPTH; g++) begin : g_ring_chk
    a_gust_max: assert property (@(posedge clk) disable iff (!rst_n)
      held_gust_r >= ring_r[g])
      else $error("held gust below a ring entry");
  end
`endif

endmodule

### test/wind_gust_from_pulse_counts_unit_tb.sv
// ----------------------------------------------------------------------------
// wind_gust_from_pulse_counts_unit_tb
// Drives windows of pulse counter readings through the wind and gust unit.
// A scoreboard predicts every result word and checks it field by field.
// Stimulus runs in phases, with each phase at its own speed_factor:
//   - the reset value, then 15, then 0, then 1, then random values
//   - still, calm, gusty, saturating and noisy windows
// Random stalls are used on both channels, except in the last phase.
// ----------------------------------------------------------------------------
module wind_gust_from_pulse_counts_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import wgust_pkg::*;

  localparam int SAMPLES_PER_WINDOW = 60;
  localparam int SAMPLE_SECONDS     = 4;
  localparam int GUST_DEPTH         = 3;
  localparam int WINDOW_SECS        = SAMPLES_PER_WINDOW * SAMPLE_SECONDS;
  localparam int PIPE_LAT           = 4;     // input to result, in cycles
  localparam int WATCHDOG_LIMIT     = 1000;  // cycles with no word moving
  localparam int MAX_REPORTS        = 50;    // keeps a broken run readable

  typedef struct packed {
    wind_t    wind;
    gust_t    gust;
    logic     done;
    reading_t delta;
  } tick_result_t;

  typedef enum {WX_STILL, WX_CALM, WX_GUSTY, WX_FULL, WX_NOISE} wx_mode_t;

  // Shadow of the unit's window state, plus the queue of predicted words
  class gust_scoreboard_t;
    factor_t      factor;
    bit           have_origin;
    reading_t     origin;
    reading_t     count_acc;
    reading_t     peak;
    idx_t         ticks;
    gust_t        ring [GUST_DEPTH];
    int unsigned  head;
    wind_t        wind_hold;
    gust_t        gust_hold;
    tick_result_t want_q [$];
    int unsigned  failures;

    function new();
      factor      = FACTOR_RESET;
      have_origin = 1'b0;
      origin      = '0;
      count_acc   = '0;
      peak        = '0;
      ticks       = '0;
      head        = 0;
      wind_hold   = '0;
      gust_hold   = '0;
      failures    = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_factor(factor_t f);
      factor = f;
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction

    // Advance the shadow state by one accepted reading
    function void note_reading(reading_t r);
      tick_result_t res;
      reading_t     count;
      reading_t     delta;
      int unsigned  w;
      int unsigned  g;
      delta    = '0;
      res.done = 1'b0;
      if (!have_origin) begin
        // first tick only latches the origin
        have_origin = 1'b1;
        origin      = r;
        count_acc   = '0;
        peak        = '0;
        ticks       = '0;
      end else begin
        count     = r - origin;          // wraps mod 2^16
        delta     = count - count_acc;
        count_acc = count;
        if (delta > peak) peak = delta;
        ticks = ticks + 1'b1;
        if (ticks >= SAMPLES_PER_WINDOW) begin
          w = (32'(factor) * 32'(count_acc) + WINDOW_SECS / 2) / WINDOW_SECS;
          g = (32'(factor) * 32'(peak) + SAMPLE_SECONDS / 2) / SAMPLE_SECONDS;
          if (w > 32'(WIND_MAX)) w = 32'(WIND_MAX);
          if (g > 32'(GUST_MAX)) g = 32'(GUST_MAX);
          wind_hold  = wind_t'(w);
          ring[head] = gust_t'(g);
          head       = (head + 1) % GUST_DEPTH;
          gust_hold  = '0;
          foreach (ring[i]) if (ring[i] > gust_hold) gust_hold = ring[i];
          res.done  = 1'b1;
          ticks     = '0;
          origin    = r;
          count_acc = '0;
          peak      = '0;
        end
      end
      res.wind  = wind_hold;
      res.gust  = gust_hold;
      res.delta = delta;
      want_q.push_back(res);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $error("%s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (want_q.size() == 0) begin
        failures++;
        $error("result word with no reading outstanding");
        return;
      end
      want = want_q.pop_front();
      match_field("wind_speed", 32'(want.wind), 32'(got.wind));
      match_field("gust_speed", 32'(want.gust), 32'(got.gust));
      match_field("window_done", 32'(want.done), 32'(got.done));
      match_field("tick_delta", 32'(want.delta), 32'(got.delta));
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     cfg_we;
  factor_t  cfg_wdata;

  wgust_in_if  in_ch ();
  wgust_out_if out_ch ();

  gust_scoreboard_t sb;
  bit               idle_on;
  int unsigned      stall_left = 0;
  int unsigned      quiet_cycles = 0;
  reading_t         stim_ctr;

  wind_gust_from_pulse_counts_unit #(
    .SAMPLES_PER_WINDOW (SAMPLES_PER_WINDOW),
    .SAMPLE_SECONDS     (SAMPLE_SECONDS),
    .GUST_DEPTH         (GUST_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Result side: ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_ch.ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(0, 6);
      out_ch.ready  <= 1'b0;
    end else begin
      out_ch.ready  <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(tick_result_t'{wind:  out_ch.wind_speed,
                                     gust:  out_ch.gust_speed,
                                     done:  out_ch.window_done,
                                     delta: out_ch.tick_delta});
  end

  // Watchdog: too long with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One reading word; valid stays high into the next call unless it idles
  task automatic send_reading(input reading_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.counter_reading <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_reading(r);
  endtask

  // Hold off input until every predicted word is back, then let the pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic load_speed_factor(input factor_t f);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_factor(f);
  endtask

  // One full window of ticks starting from the current origin
  task automatic run_window(input wx_mode_t mode, input bit allow_idle);
    reading_t base;
    reading_t d;
    base    = stim_ctr;
    idle_on = allow_idle && ($urandom_range(0, 3) != 0);
    for (int i = 1; i <= SAMPLES_PER_WINDOW; i++) begin
      unique case (mode)
        WX_STILL: d = '0;
        WX_CALM:  d = reading_t'($urandom_range(0, 25));
        WX_GUSTY: begin
          if ($urandom_range(0, 9) == 0) d = reading_t'($urandom_range(0, 65535));
          else d = reading_t'($urandom_range(0, 60));
        end
        WX_FULL: begin
          // zero, one, full wrap, big steps for gust saturation
          unique case (i)
            1:       d = 16'h0000;
            2:       d = 16'h0001;
            3:       d = 16'hFFFF;
            4:       d = 16'h8000;
            5:       d = 16'h7FFF;
            default: d = reading_t'($urandom_range(0, 300));
          endcase
        end
        default:  d = reading_t'($urandom);
      endcase
      if (mode == WX_NOISE)
        stim_ctr = reading_t'($urandom);
      else if (mode == WX_FULL && i == SAMPLES_PER_WINDOW)
        // window count near full scale: wind saturates at the top factor
        stim_ctr = base + 16'hFFF8 + reading_t'($urandom_range(0, 7));
      else
        stim_ctr = stim_ctr + d;
      send_reading(stim_ctr);
    end
  endtask

  initial begin
    sb = new();
    idle_on               = 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.counter_reading <= '0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= FACTOR_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset factor: origin at the top of the counter, then wrap through zero
    stim_ctr = 16'hFFFF;
    send_reading(stim_ctr);
    run_window(WX_FULL, 1'b1);
    run_window(WX_STILL, 1'b1);
    drain_results();

    // top factor: both speeds saturate
    load_speed_factor(factor_t'(15));
    run_window(WX_FULL, 1'b1);
    run_window(WX_GUSTY, 1'b1);
    run_window(WX_CALM, 1'b1);
    drain_results();

    // zero factor pushes a zero gust into the ring
    load_speed_factor(factor_t'(0));
    run_window(WX_GUSTY, 1'b1);
    drain_results();

    load_speed_factor(factor_t'(1));
    run_window(WX_CALM, 1'b1);
    run_window(WX_NOISE, 1'b1);
    drain_results();

    load_speed_factor(factor_t'($urandom_range(1, 15)));
    run_window(WX_GUSTY, 1'b1);
    drain_results();

    // last phase runs at full rate on both sides; let any ready burst finish
    idle_on = 1'b0;
    while (stall_left != 0) @(posedge clk);
    load_speed_factor(factor_t'($urandom_range(0, 15)));
    run_window(WX_CALM, 1'b0);
    run_window(WX_GUSTY, 1'b0);
    idle_on = 1'b0;
    drain_results();

    if (sb.failures == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
